// ===== sv/cbm_pkg.sv =====
// Shared types and codes for the cartridge bank mapper.
package cbm_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE      = 2'd0,
        KIND_TICK       = 2'd1,
        KIND_CPU_LOOKUP = 2'd2,
        KIND_PPU_LOOKUP = 2'd3
    } t_kind;

    localparam logic [1:0] REG_PRG16 = 2'd0;
    localparam logic [1:0] REG_MODE  = 2'd1;
    localparam logic [1:0] REG_IRQ   = 2'd2;
    localparam logic [1:0] REG_BANK  = 2'd3;

    localparam int PrgRegs  = 5;
    localparam int PrgSlots = 5;
    localparam int ChrRegs  = 8;

    localparam logic [7:0] ChrBank2kAbove = 8'd32;

    typedef struct packed {
        logic [PrgSlots-1:0][8:0] prg_slot;
        logic [ChrRegs-1:0][7:0]  chr_bank;
        logic                     low_unmapped;
        logic                     chr_2k;
    } t_map_state;

    typedef struct packed {
        logic       irq_line;
        logic [1:0] mirroring;
    } t_status;

endpackage

// ===== sv/cartridge_bank_mapper_with_irq.sv =====
// Top level of the cartridge bank mapper with interrupt counter.
// Requests enter on i_in_valid / o_in_ready with kind, address and write data:
// a CPU register write, a CPU cycle tick, a CPU lookup or a PPU lookup.
// Each request gives one result on o_out_valid / i_out_ready: the IRQ line and
// mirroring after the request, the mapped ROM address and the open-bus flag.
// A request is held in an input register, handled by the register file and
// the lookup logic, and the result lands in an output register; one request
// is taken every cycle while results are taken. The user must write the CHR
// ROM size register by i_cfg_we / i_cfg_data only while idle; the block does
// not enforce it. Reset clears the bank registers, counter and IRQ, maps PRG
// slots 8, A, C, E to banks 0, 1, 30, 31 and leaves the 0x6000 window unmapped.
// When the receiver stalls, the result holds; the input register still takes
// one more request, after which o_in_ready drops until the result is taken.
module cartridge_bank_mapper_with_irq
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_irq_active,
    output logic [1:0]  o_mirroring,
    output logic [21:0] o_rom_address,
    output logic        o_open_bus
);

    logic        r_in_valid;
    t_kind       r_kind;
    logic [15:0] r_address;
    logic [7:0]  r_write_data;
    logic        r_out_valid;
    logic        r_irq;
    logic [1:0]  r_mirroring;
    logic [21:0] r_rom_address;
    logic        r_open_bus;

    logic        advance;
    t_map_state  map;
    t_status     next_status;
    logic [21:0] rom_address;
    logic        open_bus;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cbm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_advance     (advance),
        .i_kind        (r_kind),
        .i_address     (r_address),
        .i_write_data  (r_write_data),
        .o_map         (map),
        .o_next_status (next_status)
    );

    cbm_lookup u_lookup (
        .i_kind        (r_kind),
        .i_address     (r_address),
        .i_map         (map),
        .o_rom_address (rom_address),
        .o_open_bus    (open_bus)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind       <= t_kind'(i_kind);
            r_address    <= i_address;
            r_write_data <= i_write_data;
        end
        if (advance) begin
            r_irq         <= next_status.irq_line;
            r_mirroring   <= next_status.mirroring;
            r_rom_address <= rom_address;
            r_open_bus    <= open_bus;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_irq_active  = r_irq;
    assign o_mirroring   = r_mirroring;
    assign o_rom_address = r_rom_address;
    assign o_open_bus    = r_open_bus;

endmodule

// ===== sv/cbm_regs.sv =====
// Mapper register file, PRG slot map and interrupt counter.
module cbm_regs
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_advance,
    input  t_kind       i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output t_map_state  o_map,
    output t_status     o_next_status
);

    logic [7:0]                r_cfg;
    logic [7:0]                r_mode;
    logic [PrgRegs-1:0][7:0]   r_prg;
    logic [ChrRegs-1:0][7:0]   r_chr;
    logic [15:0]               r_count;
    logic                      r_irq;
    logic [PrgSlots-1:0][8:0]  r_slot;
    logic                      r_low;

    logic [7:0]                n_mode;
    logic [PrgRegs-1:0][7:0]   n_prg;
    logic [ChrRegs-1:0][7:0]   n_chr;
    logic [15:0]               n_count;
    logic                      n_irq;
    logic [PrgSlots-1:0][8:0]  n_slot;
    logic                      n_low;

    always_comb begin
        n_mode  = r_mode;
        n_prg   = r_prg;
        n_chr   = r_chr;
        n_count = r_count;
        n_irq   = r_irq;
        n_slot  = r_slot;
        n_low   = r_low;
        if (i_advance && i_kind == KIND_WRITE && i_address[15:12] == 4'h8) begin
            case (i_address[9:8])
                REG_PRG16: n_prg[4] = i_write_data;
                REG_MODE:  n_mode = i_write_data;
                REG_IRQ: begin
                    if (i_address[0]) begin
                        n_count[15:8] = i_write_data;
                    end else begin
                        n_count[7:0] = i_write_data;
                        n_irq = 1'b0;
                    end
                end
                REG_BANK: begin
                    if (i_address[4]) begin
                        if (!i_address[3]) begin
                            n_chr[i_address[2:0]] = i_write_data;
                        end
                    end else begin
                        n_prg[{1'b0, i_address[1:0]}] = {3'b000, i_write_data[4:0]};
                    end
                end
                default: ;
            endcase
            // recompute slot map from the updated registers
            if (n_mode[4]) begin
                if (n_mode[5]) begin
                    n_slot[0] = {1'b0, n_prg[3]};
                    n_low = 1'b0;
                end else begin
                    n_low = 1'b1;
                end
                n_slot[1] = {1'b0, n_prg[0]};
                n_slot[2] = {1'b0, n_prg[1]};
                n_slot[3] = {1'b0, n_prg[2]};
                n_slot[4] = 9'h01F;
            end else begin
                if (n_mode[5]) begin
                    n_slot[0] = 9'h01F;
                    n_low = 1'b0;
                end else begin
                    n_low = 1'b1;
                end
                n_slot[1] = {n_prg[4], 1'b0};
                n_slot[2] = {n_prg[4], 1'b1};
                if (!n_mode[3]) begin
                    n_slot[3] = 9'd30;
                    n_slot[4] = 9'd31;
                end
            end
        end else if (i_advance && i_kind == KIND_TICK && r_mode[7]) begin
            n_count = r_count - 16'd1;
            if (n_count == 16'd0) begin
                n_irq = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= 8'd0;
            r_mode  <= 8'd0;
            r_prg   <= '0;
            r_chr   <= '0;
            r_count <= 16'd0;
            r_irq   <= 1'b0;
            r_slot  <= {9'd31, 9'd30, 9'd1, 9'd0, 9'd0};
            r_low   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_mode  <= n_mode;
            r_prg   <= n_prg;
            r_chr   <= n_chr;
            r_count <= n_count;
            r_irq   <= n_irq;
            r_slot  <= n_slot;
            r_low   <= n_low;
        end
    end

    assign o_map.prg_slot     = r_slot;
    assign o_map.chr_bank     = r_chr;
    assign o_map.low_unmapped = r_low;
    assign o_map.chr_2k       = (r_cfg > ChrBank2kAbove);

    assign o_next_status.irq_line  = n_irq;
    assign o_next_status.mirroring = n_mode[1:0];

endmodule

// ===== sv/cbm_lookup.sv =====
// CPU and PPU address translation through the current bank map.
module cbm_lookup
    import cbm_pkg::*;
(
    input  t_kind       i_kind,
    input  logic [15:0] i_address,
    input  t_map_state  i_map,
    output logic [21:0] o_rom_address,
    output logic        o_open_bus
);

    logic [15:0] offset;
    logic [2:0]  slot;
    logic [2:0]  chr_2k_sel;

    assign offset     = i_address - 16'h6000;
    assign slot       = offset[15:13];
    assign chr_2k_sel = {i_address[12], i_address[12], i_address[11]};

    always_comb begin
        o_rom_address = 22'd0;
        o_open_bus    = 1'b0;
        case (i_kind)
            KIND_CPU_LOOKUP: begin
                if (i_address >= 16'h6000) begin
                    if (slot == 3'd0 && i_map.low_unmapped) begin
                        o_open_bus = 1'b1;
                    end else begin
                        o_rom_address = {i_map.prg_slot[slot], i_address[12:0]};
                    end
                end
            end
            KIND_PPU_LOOKUP: begin
                if (i_map.chr_2k) begin
                    o_rom_address = {3'b000, i_map.chr_bank[chr_2k_sel], i_address[10:0]};
                end else begin
                    o_rom_address = {4'b0000, i_map.chr_bank[i_address[12:10]],
                                     i_address[9:0]};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sim/cartridge_bank_mapper_with_irq_tb.sv =====
// Self-checking testbench for the cartridge bank mapper: random and directed requests vs a model.
module cartridge_bank_mapper_with_irq_tb
    import cbm_pkg::*;
();

    typedef struct {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_request;

    typedef struct {
        logic        irq_active;
        logic [1:0]  mirroring;
        logic [21:0] rom_address;
        logic        open_bus;
    } t_bus_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [7:0]  i_cfg_data   = 8'h00;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind       = 2'd0;
    logic [15:0] i_address    = 16'h0000;
    logic [7:0]  i_write_data = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_irq_active;
    logic [1:0]  o_mirroring;
    logic [21:0] o_rom_address;
    logic        o_open_bus;

    // mapper state mirrored by the predictor
    logic [7:0]  chr_size_m;
    logic [7:0]  mode_m;
    logic [7:0]  prg_m [PrgRegs];
    logic [7:0]  chr_m [ChrRegs];
    logic [15:0] count_m;
    logic        irq_m;
    logic [8:0]  slot_m [PrgSlots];
    logic        low_unmapped_m;

    t_request    pending_requests [$];
    t_bus_result expected_results [$];
    t_request    drive_req;
    t_bus_result want;
    logic        req_fire = 1'b0;
    logic        irq_before;

    int requests_queued = 0;
    int results_seen    = 0;
    int mismatches      = 0;
    int sender_pct      = 0;
    int receiver_pct    = 0;
    int cfg_writes      = 0;
    int irq_raises      = 0;
    int open_bus_hits   = 0;
    int kind_count [4]  = '{0, 0, 0, 0};

    cartridge_bank_mapper_with_irq DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_irq_active  (o_irq_active),
        .o_mirroring   (o_mirroring),
        .o_rom_address (o_rom_address),
        .o_open_bus    (o_open_bus)
    );

    always #5 i_clk = ~i_clk;

    function automatic void remap_prg_slots();
        if (mode_m[4]) begin
            if (mode_m[5]) begin
                slot_m[0]      = 9'(prg_m[3]);
                low_unmapped_m = 1'b0;
            end else begin
                low_unmapped_m = 1'b1;
            end
            slot_m[1] = 9'(prg_m[0]);
            slot_m[2] = 9'(prg_m[1]);
            slot_m[3] = 9'(prg_m[2]);
            slot_m[4] = 9'h1F;
        end else begin
            if (mode_m[5]) begin
                slot_m[0]      = 9'h1F;
                low_unmapped_m = 1'b0;
            end else begin
                low_unmapped_m = 1'b1;
            end
            slot_m[1] = {prg_m[4], 1'b0};
            slot_m[2] = {prg_m[4], 1'b1};
            // hold the upper slots in 16KB mode with bit 3
            if (!mode_m[3]) begin
                slot_m[3] = 9'd30;
                slot_m[4] = 9'd31;
            end
        end
    endfunction

    function automatic void reset_mapper_model();
        chr_size_m = 8'h00;
        mode_m     = 8'h00;
        count_m    = 16'h0000;
        irq_m      = 1'b0;
        for (int i = 0; i < PrgRegs; i++) prg_m[i] = 8'h00;
        for (int i = 0; i < ChrRegs; i++) chr_m[i] = 8'h00;
        slot_m[0] = 9'd0;
        remap_prg_slots();
    endfunction

    function automatic void apply_register_write(logic [15:0] addr, logic [7:0] data);
        case (addr[9:8])
            REG_PRG16: prg_m[4] = data;
            REG_MODE:  mode_m = data;
            REG_IRQ: begin
                if (addr[0]) begin
                    count_m[15:8] = data;
                end else begin
                    count_m[7:0] = data;
                    irq_m        = 1'b0;
                end
            end
            REG_BANK: begin
                if (addr[4]) begin
                    if (!addr[3]) chr_m[addr[2:0]] = data;
                end else begin
                    prg_m[{1'b0, addr[1:0]}] = data & 8'h1F;
                end
            end
            default: ;
        endcase
        remap_prg_slots();
    endfunction

    function automatic t_bus_result predict_request(t_request req);
        t_bus_result res;
        logic [15:0] offset;
        logic [2:0]  slot;
        logic [12:0] ppu_addr;
        res.rom_address = '0;
        res.open_bus    = 1'b0;
        case (req.kind)
            KIND_WRITE: begin
                if (req.address[15:12] == 4'h8) apply_register_write(req.address, req.write_data);
            end
            KIND_TICK: begin
                if (mode_m[7]) begin
                    count_m = count_m - 16'd1;
                    if (count_m == 16'h0000) irq_m = 1'b1;
                end
            end
            KIND_CPU_LOOKUP: begin
                if (req.address >= 16'h6000) begin
                    offset = req.address - 16'h6000;
                    slot   = offset[15:13];
                    if (slot == 3'd0 && low_unmapped_m) begin
                        res.open_bus = 1'b1;
                    end else begin
                        res.rom_address = {slot_m[slot], req.address[12:0]};
                    end
                end
            end
            KIND_PPU_LOOKUP: begin
                ppu_addr = req.address[12:0];
                // 2KB banks come from registers 0, 1, 6 and 7
                if (chr_size_m > ChrBank2kAbove) begin
                    res.rom_address = 22'({chr_m[{ppu_addr[12], ppu_addr[12], ppu_addr[11]}],
                                           ppu_addr[10:0]});
                end else begin
                    res.rom_address = 22'({chr_m[ppu_addr[12:10]], ppu_addr[9:0]});
                end
            end
            default: ;
        endcase
        res.irq_active = irq_m;
        res.mirroring  = mode_m[1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic queue_request(t_kind kind, logic [15:0] address, logic [7:0] data);
        t_request req;
        req.kind       = kind;
        req.address    = address;
        req.write_data = data;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_irq_sequence();
        logic [7:0] start;
        int         ticks;
        start = 8'($urandom_range(1, 6));
        queue_request(KIND_WRITE, 16'h8200 | 16'($urandom & 32'h0CFE), start);
        queue_request(KIND_WRITE, 16'h8201 | 16'($urandom & 32'h0CFE), 8'h00);
        queue_request(KIND_WRITE, 16'h8100 | 16'($urandom & 32'h0CFF), 8'($urandom) | 8'h80);
        ticks = start + $urandom_range(0, 2);
        repeat (ticks) queue_request(KIND_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic queue_random_request();
        int          pick;
        logic [15:0] addr;
        pick = $urandom_range(99);
        addr = 16'($urandom);
        if (pick < 5) begin
            queue_irq_sequence();
        end else if (pick < 38) begin
            queue_request(KIND_WRITE, 16'h8000 | (addr & 16'h0FFF), 8'($urandom));
        end else if (pick < 43) begin
            queue_request(KIND_WRITE, addr, 8'($urandom));
        end else if (pick < 60) begin
            queue_request(KIND_TICK, addr, 8'($urandom));
        end else if (pick < 82) begin
            if ($urandom_range(4) != 0) addr = 16'h6000 + 16'($urandom_range(16'h9FFF));
            queue_request(KIND_CPU_LOOKUP, addr, 8'($urandom));
        end else begin
            queue_request(KIND_PPU_LOOKUP, addr, 8'($urandom));
        end
    endtask

    task automatic queue_directed_requests();
        queue_request(KIND_CPU_LOOKUP, 16'h6000, 8'h00);
        queue_request(KIND_CPU_LOOKUP, 16'h5FFF, 8'hFF);
        queue_request(KIND_CPU_LOOKUP, 16'hFFFF, 8'h00);
        queue_request(KIND_CPU_LOOKUP, 16'h8000, 8'h00);
        queue_request(KIND_PPU_LOOKUP, 16'h1FFF, 8'h00);
        queue_request(KIND_PPU_LOOKUP, 16'hFFFF, 8'hFF);
        queue_request(KIND_WRITE,      16'h8100, 8'hB0);
        queue_request(KIND_WRITE,      16'h8303, 8'hFF);
        queue_request(KIND_CPU_LOOKUP, 16'h7ABC, 8'h00);
        queue_request(KIND_WRITE,      16'h8317, 8'hFF);
        queue_request(KIND_WRITE,      16'h831F, 8'h55);
        queue_request(KIND_PPU_LOOKUP, 16'h1C00, 8'h00);
        queue_request(KIND_TICK,       16'h0000, 8'h00);
        queue_request(KIND_WRITE,      16'h8200, 8'h02);
        queue_request(KIND_WRITE,      16'h8201, 8'h00);
        queue_request(KIND_TICK,       16'hFFFF, 8'hFF);
        queue_request(KIND_TICK,       16'h0000, 8'h00);
        queue_request(KIND_WRITE,      16'h9100, 8'h00);
        queue_request(KIND_WRITE,      16'h8100, 8'h08);
        queue_request(KIND_WRITE,      16'h8000, 8'hFF);
        queue_request(KIND_CPU_LOOKUP, 16'h8123, 8'h00);
        queue_request(KIND_CPU_LOOKUP, 16'hC456, 8'h00);
        queue_request(KIND_CPU_LOOKUP, 16'h6000, 8'h00);
        queue_request(KIND_WRITE,      16'h8200, 8'h00);
        queue_request(KIND_WRITE,      16'h8100, 8'h03);
    endtask

    task automatic drain_requests();
        while (requests_queued != results_seen) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_chr_size(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_writes++;
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_fire) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_pct) begin
                    drive_req = pending_requests.pop_front();
                    i_in_valid   <= 1'b1;
                    i_kind       <= drive_req.kind;
                    i_address    <= drive_req.address;
                    i_write_data <= drive_req.write_data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= receiver_pct);
        end
    end

    // result monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_mapper_model();
            req_fire = 1'b0;
        end else begin
            if (i_cfg_we) chr_size_m = i_cfg_data;
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, rom_address %0h",
                                              o_rom_address));
                end else begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (o_irq_active !== want.irq_active)
                        report_mismatch($sformatf("irq_active got %0b expected %0b",
                                                  o_irq_active, want.irq_active));
                    if (o_mirroring !== want.mirroring)
                        report_mismatch($sformatf("mirroring got %0d expected %0d",
                                                  o_mirroring, want.mirroring));
                    if (o_rom_address !== want.rom_address)
                        report_mismatch($sformatf("rom_address got %0h expected %0h",
                                                  o_rom_address, want.rom_address));
                    if (o_open_bus !== want.open_bus)
                        report_mismatch($sformatf("open_bus got %0b expected %0b",
                                                  o_open_bus, want.open_bus));
                end
            end
            req_fire = i_in_valid && o_in_ready;
            if (req_fire) begin
                irq_before = irq_m;
                expected_results.push_back(predict_request('{t_kind'(i_kind), i_address,
                                                             i_write_data}));
                kind_count[i_kind]++;
                if (!irq_before && irq_m) irq_raises++;
                if (expected_results[$].open_bus) open_bus_hits++;
            end
        end
    end

    initial begin
        int         phase;
        int         target;
        logic [7:0] cfg_value;
        int         phase_items [5]  = '{300, 350, 350, 450, 450};
        int         phase_sender [5] = '{0, 85, 0, 7, 0};
        int         phase_recv [5]   = '{0, 0, 85, 7, 0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       cfg_value = 8'd0;
                1:       cfg_value = 8'd255;
                2:       cfg_value = ChrBank2kAbove;
                3:       cfg_value = ChrBank2kAbove + 8'd1;
                default: cfg_value = 8'($urandom_range(255));
            endcase
            write_chr_size(cfg_value);
            sender_pct   = phase_sender[phase];
            receiver_pct = phase_recv[phase];
            if (phase == 0) queue_directed_requests();
            target = requests_queued + phase_items[phase] / 2;
            while (requests_queued < target) queue_random_request();
            // hold the sender until every result is back
            drain_requests();
            target = requests_queued + phase_items[phase] - phase_items[phase] / 2;
            while (requests_queued < target) queue_random_request();
            drain_requests();
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("Covered %0d requests: %0d writes, %0d ticks, %0d CPU and %0d PPU lookups",
                 results_seen, kind_count[KIND_WRITE], kind_count[KIND_TICK],
                 kind_count[KIND_CPU_LOOKUP], kind_count[KIND_PPU_LOOKUP]);
        $display("CHR size settings %0d, IRQ raised %0d times, open-bus lookups %0d",
                 cfg_writes, irq_raises, open_bus_hits);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
